FILE: src/clu_pkg.sv
package clu_pkg;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  opcode;
        logic [15:0] imm_word;
        logic [7:0]  read_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  dest;
        logic [15:0] dest_value;
        logic [15:0] mem_addr;
        logic [7:0]  mem_wdata;
    } t_out_item;

    // command codes
    localparam logic CMD_EXEC = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_REG   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    // destination codes
    localparam logic [3:0] DEST_B  = 4'd0;
    localparam logic [3:0] DEST_C  = 4'd1;
    localparam logic [3:0] DEST_D  = 4'd2;
    localparam logic [3:0] DEST_E  = 4'd3;
    localparam logic [3:0] DEST_H  = 4'd4;
    localparam logic [3:0] DEST_L  = 4'd5;
    localparam logic [3:0] DEST_A  = 4'd6;
    localparam logic [3:0] DEST_BC = 4'd7;
    localparam logic [3:0] DEST_DE = 4'd8;
    localparam logic [3:0] DEST_HL = 4'd9;
    localparam logic [3:0] DEST_SP = 4'd10;

    // 3-bit register field of the move group
    localparam logic [2:0] FLD_B  = 3'd0;
    localparam logic [2:0] FLD_C  = 3'd1;
    localparam logic [2:0] FLD_D  = 3'd2;
    localparam logic [2:0] FLD_E  = 3'd3;
    localparam logic [2:0] FLD_H  = 3'd4;
    localparam logic [2:0] FLD_L  = 3'd5;
    localparam logic [2:0] FLD_HL = 3'd6;
    localparam logic [2:0] FLD_A  = 3'd7;

    // opcodes
    localparam logic [1:0] OP_MOVE_GRP = 2'b01;
    localparam logic [7:0] OP_HALT     = 8'h76;
    localparam logic [7:0] OP_LD_BC_NN = 8'h01;
    localparam logic [7:0] OP_LD_DE_NN = 8'h11;
    localparam logic [7:0] OP_LD_HL_NN = 8'h21;
    localparam logic [7:0] OP_LD_SP_NN = 8'h31;
    localparam logic [7:0] OP_ST_BC_A  = 8'h02;
    localparam logic [7:0] OP_ST_DE_A  = 8'h12;
    localparam logic [7:0] OP_LD_B_N   = 8'h06;
    localparam logic [7:0] OP_LD_D_N   = 8'h16;
    localparam logic [7:0] OP_LD_H_N   = 8'h26;
    localparam logic [7:0] OP_ST_HL_N  = 8'h36;
    localparam logic [7:0] OP_LD_A_BC  = 8'h0A;
    localparam logic [7:0] OP_LD_A_DE  = 8'h1A;
    localparam logic [7:0] OP_LD_C_N   = 8'h0E;
    localparam logic [7:0] OP_LD_E_N   = 8'h1E;
    localparam logic [7:0] OP_LD_L_N   = 8'h2E;
    localparam logic [7:0] OP_LD_A_N   = 8'h3E;
    localparam logic [7:0] OP_ST_IOC_A = 8'hE2;
    localparam logic [7:0] OP_LD_A_IOC = 8'hF2;
    localparam logic [7:0] OP_ST_NN_A  = 8'hEA;
    localparam logic [7:0] OP_LD_A_NN  = 8'hFA;
    localparam logic [7:0] OP_LD_HL_SP = 8'hF8;
    localparam logic [7:0] OP_LD_SP_HL = 8'hF9;

    localparam logic [7:0] IO_PAGE = 8'hFF;

    // move-group field to destination code; the (HL) field maps to A, unused
    function automatic logic [3:0] move_dest(input logic [2:0] fld);
        logic [3:0] d;
        case (fld)
            FLD_B:   d = DEST_B;
            FLD_C:   d = DEST_C;
            FLD_D:   d = DEST_D;
            FLD_E:   d = DEST_E;
            FLD_H:   d = DEST_H;
            FLD_L:   d = DEST_L;
            default: d = DEST_A;
        endcase
        return d;
    endfunction

endpackage

FILE: src/cpu_load_instruction_unit.sv
// An item passes through the input register, then the result register, which is
// written through one pass of decode and a 16-bit add.
// Throughput: one item per cycle while the receiver takes results; the register file updates as each item
// leaves the input register, so back-to-back items see current state.
// Reset (synchronous, active low) clears the architectural registers, the pending read
// and both valid flags.
module cpu_load_instruction_unit
    import clu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic [7:0]  r_b, r_c, r_d, r_e, r_h, r_l, r_a;
    logic [15:0] r_sp;
    logic        r_pending;
    logic [2:0]  r_pend_dest;

    logic        advance;
    t_out_item   n_out;
    logic [15:0] hl, bc, de;
    logic [2:0]  src_fld, dst_fld;
    logic [7:0]  src_byte;
    logic [7:0]  imm_lo;
    logic [3:0]  pend_code;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign hl      = {r_h, r_l};
    assign bc      = {r_b, r_c};
    assign de      = {r_d, r_e};
    assign src_fld = r_in.opcode[2:0];
    assign dst_fld = r_in.opcode[5:3];
    assign imm_lo  = r_in.imm_word[7:0];
    assign pend_code = (r_pend_dest > DEST_A[2:0]) ? DEST_A : {1'b0, r_pend_dest};

    always_comb begin
        case (src_fld)
            FLD_B:   src_byte = r_b;
            FLD_C:   src_byte = r_c;
            FLD_D:   src_byte = r_d;
            FLD_E:   src_byte = r_e;
            FLD_H:   src_byte = r_h;
            FLD_L:   src_byte = r_l;
            default: src_byte = r_a;
        endcase
    end

    // decode and execute one item; the result also describes the register write
    always_comb begin
        n_out      = '0;
        n_out.kind = KIND_ERR;
        if (r_in.cmd == CMD_DATA) begin
            if (r_pending) begin
                n_out.kind       = KIND_REG;
                n_out.dest       = pend_code;
                n_out.dest_value = {8'h00, r_in.read_byte};
            end
        end else if (!r_pending) begin
            if (r_in.opcode[7:6] == OP_MOVE_GRP && r_in.opcode != OP_HALT) begin
                if (src_fld == FLD_HL) begin
                    n_out.kind     = KIND_READ;
                    n_out.dest     = move_dest(dst_fld);
                    n_out.mem_addr = hl;
                end else if (dst_fld == FLD_HL) begin
                    n_out.kind      = KIND_WRITE;
                    n_out.mem_addr  = hl;
                    n_out.mem_wdata = src_byte;
                end else begin
                    n_out.kind       = KIND_REG;
                    n_out.dest       = move_dest(dst_fld);
                    n_out.dest_value = {8'h00, src_byte};
                end
            end else begin
                case (r_in.opcode)
                    OP_LD_BC_NN, OP_LD_DE_NN, OP_LD_HL_NN, OP_LD_SP_NN: begin
                        n_out.kind       = KIND_REG;
                        n_out.dest       = (r_in.opcode == OP_LD_BC_NN) ? DEST_BC :
                                           (r_in.opcode == OP_LD_DE_NN) ? DEST_DE :
                                           (r_in.opcode == OP_LD_HL_NN) ? DEST_HL : DEST_SP;
                        n_out.dest_value = r_in.imm_word;
                    end
                    OP_ST_BC_A: begin
                        n_out.kind      = KIND_WRITE;
                        n_out.mem_addr  = bc;
                        n_out.mem_wdata = r_a;
                    end
                    OP_ST_DE_A: begin
                        n_out.kind      = KIND_WRITE;
                        n_out.mem_addr  = de;
                        n_out.mem_wdata = r_a;
                    end
                    OP_LD_B_N, OP_LD_D_N, OP_LD_H_N, OP_LD_C_N,
                    OP_LD_E_N, OP_LD_L_N, OP_LD_A_N: begin
                        n_out.kind       = KIND_REG;
                        n_out.dest       = move_dest(dst_fld);
                        n_out.dest_value = {8'h00, imm_lo};
                    end
                    OP_ST_HL_N: begin
                        n_out.kind      = KIND_WRITE;
                        n_out.mem_addr  = hl;
                        n_out.mem_wdata = imm_lo;
                    end
                    OP_LD_A_BC: begin
                        n_out.kind     = KIND_READ;
                        n_out.dest     = DEST_A;
                        n_out.mem_addr = bc;
                    end
                    OP_LD_A_DE: begin
                        n_out.kind     = KIND_READ;
                        n_out.dest     = DEST_A;
                        n_out.mem_addr = de;
                    end
                    OP_ST_IOC_A: begin
                        n_out.kind      = KIND_WRITE;
                        n_out.mem_addr  = {IO_PAGE, r_c};
                        n_out.mem_wdata = r_a;
                    end
                    OP_LD_A_IOC: begin
                        n_out.kind     = KIND_READ;
                        n_out.dest     = DEST_A;
                        n_out.mem_addr = {IO_PAGE, r_c};
                    end
                    OP_ST_NN_A: begin
                        n_out.kind      = KIND_WRITE;
                        n_out.mem_addr  = r_in.imm_word;
                        n_out.mem_wdata = r_a;
                    end
                    OP_LD_A_NN: begin
                        n_out.kind     = KIND_READ;
                        n_out.dest     = DEST_A;
                        n_out.mem_addr = r_in.imm_word;
                    end
                    OP_LD_HL_SP: begin
                        n_out.kind       = KIND_REG;
                        n_out.dest       = DEST_HL;
                        n_out.dest_value = r_sp + {{8{imm_lo[7]}}, imm_lo};
                    end
                    OP_LD_SP_HL: begin
                        n_out.kind       = KIND_REG;
                        n_out.dest       = DEST_SP;
                        n_out.dest_value = hl;
                    end
                    default: n_out.kind = KIND_ERR;
                endcase
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b         <= '0;
            r_c         <= '0;
            r_d         <= '0;
            r_e         <= '0;
            r_h         <= '0;
            r_l         <= '0;
            r_a         <= '0;
            r_sp        <= '0;
            r_pending   <= 1'b0;
            r_pend_dest <= '0;
        end else if (advance) begin
            if (n_out.kind == KIND_REG) begin
                case (n_out.dest)
                    DEST_B:  r_b <= n_out.dest_value[7:0];
                    DEST_C:  r_c <= n_out.dest_value[7:0];
                    DEST_D:  r_d <= n_out.dest_value[7:0];
                    DEST_E:  r_e <= n_out.dest_value[7:0];
                    DEST_H:  r_h <= n_out.dest_value[7:0];
                    DEST_L:  r_l <= n_out.dest_value[7:0];
                    DEST_A:  r_a <= n_out.dest_value[7:0];
                    DEST_BC: {r_b, r_c} <= n_out.dest_value;
                    DEST_DE: {r_d, r_e} <= n_out.dest_value;
                    DEST_HL: {r_h, r_l} <= n_out.dest_value;
                    DEST_SP: r_sp <= n_out.dest_value;
                    default: r_sp <= r_sp;
                endcase
            end
            if (n_out.kind == KIND_READ) begin
                r_pending   <= 1'b1;
                r_pend_dest <= n_out.dest[2:0];
            end else if (r_in.cmd == CMD_DATA && r_pending) begin
                r_pending <= 1'b0;
            end
        end
    end

    // no second read request may be issued while one is outstanding
    a_no_double_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_pending |-> n_out.kind != KIND_READ)
        else $error("read request issued while a read is pending");

    a_read_sets_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_out.kind == KIND_READ |=> r_pending)
        else $error("read request did not mark a pending read");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_ERR |->
            o_out_item.dest == '0 && o_out_item.dest_value == '0 &&
            o_out_item.mem_addr == '0 && o_out_item.mem_wdata == '0)
        else $error("error result carries non-zero fields");

    a_dest_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.kind == KIND_REG |-> o_out_item.dest <= DEST_SP)
        else $error("register write to unknown destination");

endmodule

FILE: bench/tb_top.sv
module tb_top;
    import clu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS = 850;
    localparam int          DRAIN_LIMIT  = 50000;
    localparam int          LOAD_OPS_N   = 22;
    localparam logic [7:0]  OP_RST38     = 8'hFF;   // not part of the load group

    localparam logic [7:0] LOAD_OPS [LOAD_OPS_N] = '{
        OP_LD_BC_NN, OP_LD_DE_NN, OP_LD_HL_NN, OP_LD_SP_NN, OP_ST_BC_A, OP_ST_DE_A,
        OP_LD_B_N, OP_LD_D_N, OP_LD_H_N, OP_ST_HL_N, OP_LD_A_BC, OP_LD_A_DE,
        OP_LD_C_N, OP_LD_E_N, OP_LD_L_N, OP_LD_A_N, OP_ST_IOC_A, OP_LD_A_IOC,
        OP_ST_NN_A, OP_LD_A_NN, OP_LD_HL_SP, OP_LD_SP_HL
    };

    typedef struct packed {
        t_in_item  stim;
        logic      typed;
        t_out_item want;
    } t_vector;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_item   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    // shadow register file
    logic [7:0]  gpr [0:6];
    logic [15:0] sp_q;
    logic        rd_pending;
    logic [3:0]  rd_dest;

    t_out_item   load_results_due [$];
    int          mismatches = 0;
    bit          sender_calm = 1'b0;

    cpu_load_instruction_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got, want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // ---- result builders ----
    function automatic t_out_item reg_res(input logic [3:0] d, input logic [15:0] v);
        t_out_item r;
        r            = '0;
        r.kind       = KIND_REG;
        r.dest       = d;
        r.dest_value = v;
        return r;
    endfunction

    function automatic t_out_item wr_res(input logic [15:0] a, input logic [7:0] b);
        t_out_item r;
        r           = '0;
        r.kind      = KIND_WRITE;
        r.mem_addr  = a;
        r.mem_wdata = b;
        return r;
    endfunction

    function automatic t_out_item rd_res(input logic [3:0] d, input logic [15:0] a);
        t_out_item r;
        r          = '0;
        r.kind     = KIND_READ;
        r.dest     = d;
        r.mem_addr = a;
        return r;
    endfunction

    function automatic t_out_item err_res();
        t_out_item r;
        r      = '0;
        r.kind = KIND_ERR;
        return r;
    endfunction

    function automatic t_in_item ex(input logic [7:0] op, input logic [15:0] imm);
        t_in_item it;
        it          = '0;
        it.cmd      = CMD_EXEC;
        it.opcode   = op;
        it.imm_word = imm;
        return it;
    endfunction

    function automatic t_in_item dat(input logic [7:0] b);
        t_in_item it;
        it           = '0;
        it.cmd       = CMD_DATA;
        it.read_byte = b;
        return it;
    endfunction

    // ---- predictor ----
    function automatic logic [3:0] field_reg(input logic [2:0] f);
        return (f == FLD_A) ? DEST_A : {1'b0, f};
    endfunction

    function automatic logic [7:0] get_byte(input logic [3:0] d);
        return gpr[d[2:0]];
    endfunction

    function automatic t_out_item set_byte(input logic [3:0] d, input logic [7:0] v);
        gpr[d[2:0]] = v;
        return reg_res(d, {8'h00, v});
    endfunction

    function automatic t_out_item set_pair(input logic [3:0] p, input logic [15:0] v);
        case (p)
            DEST_BC: begin
                gpr[DEST_B[2:0]] = v[15:8];
                gpr[DEST_C[2:0]] = v[7:0];
            end
            DEST_DE: begin
                gpr[DEST_D[2:0]] = v[15:8];
                gpr[DEST_E[2:0]] = v[7:0];
            end
            DEST_HL: begin
                gpr[DEST_H[2:0]] = v[15:8];
                gpr[DEST_L[2:0]] = v[7:0];
            end
            default: sp_q = v;
        endcase
        return reg_res(p, v);
    endfunction

    function automatic t_out_item start_read(input logic [3:0] d, input logic [15:0] a);
        rd_pending = 1'b1;
        rd_dest    = d;
        return rd_res(d, a);
    endfunction

    function automatic t_out_item predict_load(input t_in_item it);
        t_out_item   r;
        logic [7:0]  lo;
        logic [15:0] hl, bc, de;
        logic [2:0]  src, dst;
        r   = err_res();
        lo  = it.imm_word[7:0];
        hl  = {get_byte(DEST_H), get_byte(DEST_L)};
        bc  = {get_byte(DEST_B), get_byte(DEST_C)};
        de  = {get_byte(DEST_D), get_byte(DEST_E)};
        src = it.opcode[2:0];
        dst = it.opcode[5:3];
        if (it.cmd == CMD_DATA) begin
            if (rd_pending) begin
                rd_pending = 1'b0;
                r = set_byte(rd_dest, it.read_byte);
            end
        end else if (!rd_pending) begin
            if (it.opcode[7:6] == OP_MOVE_GRP && it.opcode != OP_HALT) begin
                if (src == FLD_HL)
                    r = start_read(field_reg(dst), hl);
                else if (dst == FLD_HL)
                    r = wr_res(hl, get_byte(field_reg(src)));
                else
                    r = set_byte(field_reg(dst), get_byte(field_reg(src)));
            end else begin
                case (it.opcode)
                    OP_LD_BC_NN: r = set_pair(DEST_BC, it.imm_word);
                    OP_LD_DE_NN: r = set_pair(DEST_DE, it.imm_word);
                    OP_LD_HL_NN: r = set_pair(DEST_HL, it.imm_word);
                    OP_LD_SP_NN: r = set_pair(DEST_SP, it.imm_word);
                    OP_ST_BC_A:  r = wr_res(bc, get_byte(DEST_A));
                    OP_ST_DE_A:  r = wr_res(de, get_byte(DEST_A));
                    OP_LD_B_N:   r = set_byte(DEST_B, lo);
                    OP_LD_D_N:   r = set_byte(DEST_D, lo);
                    OP_LD_H_N:   r = set_byte(DEST_H, lo);
                    OP_ST_HL_N:  r = wr_res(hl, lo);
                    OP_LD_A_BC:  r = start_read(DEST_A, bc);
                    OP_LD_A_DE:  r = start_read(DEST_A, de);
                    OP_LD_C_N:   r = set_byte(DEST_C, lo);
                    OP_LD_E_N:   r = set_byte(DEST_E, lo);
                    OP_LD_L_N:   r = set_byte(DEST_L, lo);
                    OP_LD_A_N:   r = set_byte(DEST_A, lo);
                    OP_ST_IOC_A: r = wr_res({IO_PAGE, get_byte(DEST_C)}, get_byte(DEST_A));
                    OP_LD_A_IOC: r = start_read(DEST_A, {IO_PAGE, get_byte(DEST_C)});
                    OP_ST_NN_A:  r = wr_res(it.imm_word, get_byte(DEST_A));
                    OP_LD_A_NN:  r = start_read(DEST_A, it.imm_word);
                    // r8 sign-extended, 16-bit wrap
                    OP_LD_HL_SP: r = set_pair(DEST_HL, sp_q + {{8{lo[7]}}, lo});
                    OP_LD_SP_HL: r = set_pair(DEST_SP, hl);
                    default:     r = err_res();
                endcase
            end
        end
        return r;
    endfunction

    // ---- stimulus ----
    function automatic int idle_len(input bit calm);
        int pick;
        pick = $urandom_range(0, 99);
        if (calm || pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_in_item random_load();
        t_in_item it;
        int       pick;
        it.cmd       = CMD_EXEC;
        it.opcode    = $urandom_range(0, 255);
        it.imm_word  = $urandom_range(0, 65535);
        it.read_byte = $urandom_range(0, 255);
        pick         = $urandom_range(0, 99);
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0:       it.imm_word = 16'h0000;
                1:       it.imm_word = 16'hFFFF;
                2:       it.imm_word = 16'h0080;
                default: it.imm_word = 16'h007F;
            endcase
        end
        if (rd_pending) begin
            // mostly answer the read, occasionally break the sequence
            if (pick < 85)
                it.cmd = CMD_DATA;
        end else if (pick < 6) begin
            it.cmd = CMD_DATA;
        end else if (pick >= 12 && pick < 55) begin
            it.opcode[7:6] = OP_MOVE_GRP;
        end else if (pick >= 55) begin
            it.opcode = LOAD_OPS[$urandom_range(0, LOAD_OPS_N - 1)];
        end
        return it;
    endfunction

    task automatic send_load(input t_in_item it, input logic typed, input t_out_item want);
        int        gap;
        t_out_item pred;
        gap = idle_len(sender_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = predict_load(it);
        load_results_due.push_back(typed ? want : pred);
    endtask

    // result side: checked against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (load_results_due.size() == 0) begin
                report_mismatch("result with nothing outstanding");
            end else begin
                want = load_results_due.pop_front();
                check_field("kind", o_out_item.kind, want.kind);
                check_field("dest", o_out_item.dest, want.dest);
                check_field("dest_value", o_out_item.dest_value, want.dest_value);
                check_field("mem_addr", o_out_item.mem_addr, want.mem_addr);
                check_field("mem_wdata", o_out_item.mem_wdata, want.mem_wdata);
            end
        end
    end

    // receiver back-pressure
    initial begin
        int stall;
        int run;
        forever begin
            if ($urandom_range(0, 9) < 3) begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(1, 3);
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
            repeat (run) @(posedge i_clk);
        end
    end

    initial begin
        t_vector directed [25];
        int      guard;
        gpr        = '{default: 8'h00};
        sp_q       = 16'h0000;
        rd_pending = 1'b0;
        rd_dest    = DEST_B;

        // state after reset is all zero, so most rows can be read off directly
        directed[0]  = '{ex({OP_MOVE_GRP, FLD_B, FLD_C}, 16'h0), 1'b1, reg_res(DEST_B, 16'h0)};
        directed[1]  = '{ex(OP_HALT, 16'hFFFF), 1'b1, err_res()};
        directed[2]  = '{ex(OP_RST38, 16'h0), 1'b1, err_res()};
        directed[3]  = '{dat(8'hFF), 1'b1, err_res()};   // no read outstanding
        directed[4]  = '{ex(OP_LD_SP_NN, 16'hFFFF), 1'b1, reg_res(DEST_SP, 16'hFFFF)};
        directed[5]  = '{ex(OP_LD_HL_SP, 16'h0080), 1'b1, reg_res(DEST_HL, 16'hFF7F)};
        directed[6]  = '{ex(OP_LD_HL_SP, 16'hFF7F), 1'b1, reg_res(DEST_HL, 16'h007E)};
        directed[7]  = '{ex(OP_LD_BC_NN, 16'hFFFF), 1'b1, reg_res(DEST_BC, 16'hFFFF)};
        directed[8]  = '{ex(OP_LD_DE_NN, 16'h0000), 1'b1, reg_res(DEST_DE, 16'h0000)};
        directed[9]  = '{ex(OP_LD_A_N, 16'hAA55), 1'b1, reg_res(DEST_A, 16'h0055)};
        directed[10] = '{ex(OP_ST_BC_A, 16'h0), 1'b1, wr_res(16'hFFFF, 8'h55)};
        directed[11] = '{ex(OP_ST_IOC_A, 16'h0), 1'b1, wr_res(16'hFFFF, 8'h55)};
        directed[12] = '{ex(OP_ST_NN_A, 16'h1234), 1'b1, wr_res(16'h1234, 8'h55)};
        directed[13] = '{ex(OP_ST_HL_N, 16'h00FF), 1'b1, wr_res(16'h007E, 8'hFF)};
        directed[14] = '{ex(OP_LD_SP_HL, 16'h0), 1'b1, reg_res(DEST_SP, 16'h007E)};
        directed[15] = '{ex(OP_LD_A_BC, 16'h0), 1'b1, rd_res(DEST_A, 16'hFFFF)};
        directed[16] = '{ex({OP_MOVE_GRP, FLD_B, FLD_B}, 16'h0), 1'b1, err_res()};
        directed[17] = '{dat(8'hFF), 1'b1, reg_res(DEST_A, 16'h00FF)};
        directed[18] = '{ex({OP_MOVE_GRP, FLD_B, FLD_HL}, 16'h0), 1'b1,
                         rd_res(DEST_B, 16'h007E)};
        directed[19] = '{dat(8'h00), 1'b1, reg_res(DEST_B, 16'h0000)};
        directed[20] = '{ex(OP_LD_A_DE, 16'h0), 1'b1, rd_res(DEST_A, 16'h0000)};
        directed[21] = '{dat(8'h80), 1'b1, reg_res(DEST_A, 16'h0080)};
        directed[22] = '{ex(OP_LD_A_IOC, 16'h0), 1'b1, rd_res(DEST_A, 16'hFFFF)};
        directed[23] = '{dat(8'h3C), 1'b1, reg_res(DEST_A, 16'h003C)};
        directed[24] = '{ex({OP_MOVE_GRP, FLD_HL, FLD_A}, 16'h0), 1'b0, err_res()};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_load(directed[i].stim, directed[i].typed, directed[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0)
                sender_calm = ($urandom_range(0, 3) == 0);
            send_load(random_load(), 1'b0, err_res());
        end
        i_in_valid <= 1'b0;

        guard = 0;
        while (load_results_due.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (load_results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", load_results_due.size()));

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
